// ----- src/twwf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twwf_pkg
// Shared types and character codes of the text word wrap formatter.
// ----------------------------------------------------------------------------
package twwf_pkg;

  localparam int CHAR_W = 7;
  localparam int CODE_W = 8;
  localparam int COL_W  = 8;

  localparam logic [CHAR_W-1:0] LINE_WIDTH_RESET = 7'd78;

  localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 7'h08;
  localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_SP    = 7'h20;
  localparam logic [CHAR_W-1:0] CH_EXCL  = 7'h21;
  localparam logic [CHAR_W-1:0] CH_DQUOT = 7'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOT = 7'h27;
  localparam logic [CHAR_W-1:0] CH_COMMA = 7'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_QUEST = 7'h3F;
  localparam logic [CHAR_W-1:0] CH_AT    = 7'h40;
  localparam logic [CHAR_W-1:0] CH_BSL   = 7'h5C;
  localparam logic [CHAR_W-1:0] CH_CARET = 7'h5E;
  localparam logic [CHAR_W-1:0] CH_UNDER = 7'h5F;
  localparam logic [CHAR_W-1:0] CH_GRAVE = 7'h60;
  localparam logic [CHAR_W-1:0] CH_S     = 7'h73;
  localparam logic [CHAR_W-1:0] CH_BAR   = 7'h7C;
  localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;
  localparam logic [CHAR_W-1:0] CH_CAP   = 7'h7F;
  localparam logic [CHAR_W-1:0] CASE_OFS = 7'h20;

  typedef struct packed {
    logic load;
    logic take;
    logic head;
    logic word;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic slot_any;
    logic take_flush;
    logic head_ok;
    logic emit_ok;
    logic last_index;
    logic hold_valid;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- src/twwf_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twwf_in_if
// Input channel: one game text character item with its flags.
// ----------------------------------------------------------------------------
interface twwf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [twwf_pkg::CODE_W-1:0] char_code;
  logic                        side_channel;
  logic                        plural;

  modport source (output valid, cmd, char_code, side_channel, plural, input ready);
  modport sink   (input valid, cmd, char_code, side_channel, plural, output ready);
endinterface
`default_nettype wire

// ----- src/twwf_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twwf_out_if
// Output channel: one console character item.
// ----------------------------------------------------------------------------
interface twwf_out_if;
  logic                        valid;
  logic                        ready;
  logic [twwf_pkg::CHAR_W-1:0] out_char;
  logic                        last_of_run;

  modport source (output valid, out_char, last_of_run, input ready);
  modport sink   (input valid, out_char, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- src/twwf_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twwf_ctrl
// Sequencer: takes an item, runs its character steps and word flushes,
// then closes the run.
// ----------------------------------------------------------------------------
module twwf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire twwf_pkg::status_t status,
  output twwf_pkg::cmd_t         cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_HEAD = 2'd2;
  localparam logic [1:0] S_WORD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        if (status.slot_any) begin
          cmd.take = 1'b1;
          if (status.take_flush) begin
            state_next = S_HEAD;
          end
        end else if (!status.hold_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HEAD: begin
        if (status.head_ok) begin
          cmd.head   = 1'b1;
          state_next = S_WORD;
        end
      end
      S_WORD: begin
        if (status.emit_ok) begin
          cmd.word = 1'b1;
          if (status.last_index) begin
            state_next = S_ACC;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.take, cmd.head, cmd.word, cmd.finish}))
    else $error("more than one datapath command at once");

  a_word_room: assert property (@(posedge clk) disable iff (rst)
    cmd.word |-> status.emit_ok)
    else $error("word character emitted without output room");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !status.hold_valid)
    else $error("idle with an undelivered character held");

endmodule
`default_nettype wire

// ----- src/twwf_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twwf_dp
// Datapath: character cleanup, word store, column tracking and the
// output stage with one held character for marking the end of a run.
// ----------------------------------------------------------------------------
module twwf_dp #(
  parameter int WORD_LIMIT = 60
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire twwf_pkg::cmd_t              cmd,
  output twwf_pkg::status_t                status,
  input  wire logic                        in_cmd,
  input  wire logic [twwf_pkg::CODE_W-1:0] in_char_code,
  input  wire logic                        in_side_channel,
  input  wire logic                        in_plural,
  input  wire logic                        cfg_we,
  input  wire logic [twwf_pkg::CHAR_W-1:0] cfg_data,
  twwf_out_if.source                       out_ch
);

  localparam int DEPTH = WORD_LIMIT + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int CW    = twwf_pkg::CHAR_W;
  localparam int SUM_W = twwf_pkg::COL_W + 1;

  logic [CW-1:0]                 line_width;
  logic                          cap;
  logic [CW-1:0]                 prev;
  logic [LEN_W-1:0]              len;
  logic [twwf_pkg::COL_W-1:0]    column;
  logic [IDX_W-1:0]              idx;
  logic [CW-1:0]                 first_char;
  logic                          pre_valid;
  logic [CW-1:0]                 pre_char;
  logic                          main_valid;
  logic [CW-1:0]                 main_char;
  logic [CW-1:0]                 mem [DEPTH];
  logic [CW-1:0]                 rd_data;
  logic                          hold_valid;
  logic [CW-1:0]                 hold_char;
  logic                          out_valid;
  logic [CW-1:0]                 out_char;
  logic                          out_last;

  logic                          cap_next;
  logic                          col_reset;
  logic                          dec_pre_v;
  logic [CW-1:0]                 dec_pre_c;
  logic                          dec_main_v;
  logic [CW-1:0]                 dec_c;
  logic [CW-1:0]                 x;
  logic                          bar_skip;
  logic                          wrap;
  logic                          head_emit;
  logic                          out_free;
  logic                          emit_ok;
  logic                          emit_en;
  logic [CW-1:0]                 emit_char;
  logic [LEN_W-1:0]              rd_addr;
  logic [twwf_pkg::COL_W-1:0]    bumped;
  logic [twwf_pkg::COL_W-1:0]    col_word_next;
  logic                          last_index;

  function automatic logic is_letter(input logic [CW-1:0] c);
    return ((c >= 7'h41) && (c <= 7'h5A)) || ((c >= 7'h61) && (c <= 7'h7A));
  endfunction

  // item decode
  always_comb begin
    dec_c      = in_char_code[CW-1:0];
    cap_next   = cap;
    col_reset  = 1'b0;
    dec_pre_v  = 1'b0;
    dec_pre_c  = twwf_pkg::CH_LF;
    dec_main_v = 1'b0;
    if (dec_c == twwf_pkg::CH_CAP) begin
      cap_next = 1'b1;
    end else if (dec_c == twwf_pkg::CH_NUL) begin
      col_reset = 1'b1;
    end else if (!in_side_channel) begin
      if (dec_c == twwf_pkg::CH_CARET) begin
        dec_c = twwf_pkg::CH_LF;
      end
      if (dec_c == twwf_pkg::CH_AT) begin
        dec_c = in_plural ? twwf_pkg::CH_NUL : twwf_pkg::CH_S;
      end
      if (cap) begin
        if ((dec_c > twwf_pkg::CH_GRAVE) && (dec_c < twwf_pkg::CH_BAR)) begin
          dec_c    = dec_c - twwf_pkg::CASE_OFS;
          cap_next = 1'b0;
        end else if (((dec_c > twwf_pkg::CH_AT) && (dec_c < twwf_pkg::CH_BSL)) ||
                     (dec_c == twwf_pkg::CH_SQUOT) || (dec_c == twwf_pkg::CH_DQUOT)) begin
          cap_next = 1'b0;
        end
      end
      if ((dec_c == twwf_pkg::CH_TILDE) || (dec_c == twwf_pkg::CH_EXCL) ||
          (dec_c == twwf_pkg::CH_DOT) || (dec_c == twwf_pkg::CH_QUEST) ||
          (dec_c == twwf_pkg::CH_LF)) begin
        cap_next = 1'b1;
      end
      if (dec_c == twwf_pkg::CH_CR) begin
        dec_c = twwf_pkg::CH_LF;
      end
      if (((dec_c == twwf_pkg::CH_LF) || (dec_c == twwf_pkg::CH_SP)) && (dec_c == prev)) begin
        dec_c = twwf_pkg::CH_NUL;
      end
      if (dec_c == twwf_pkg::CH_TILDE) begin
        if (prev != twwf_pkg::CH_LF) begin
          dec_pre_v = 1'b1;
          dec_pre_c = twwf_pkg::CH_LF;
        end
        dec_c = twwf_pkg::CH_LF;
      end
      if (dec_c == twwf_pkg::CH_UNDER) begin
        dec_c = twwf_pkg::CH_SP;
      end
      if (dec_c != twwf_pkg::CH_NUL) begin
        dec_main_v = 1'b1;
        if (((prev == twwf_pkg::CH_COMMA) || (prev == twwf_pkg::CH_DOT) ||
             (prev == twwf_pkg::CH_EXCL) || (prev == twwf_pkg::CH_QUEST)) &&
            is_letter(dec_c)) begin
          dec_pre_v = 1'b1;
          dec_pre_c = twwf_pkg::CH_SP;
        end
      end
    end
  end

  // character step and flush support
  always_comb begin
    x          = pre_valid ? pre_char : main_char;
    bar_skip   = (prev == twwf_pkg::CH_BAR);
    wrap       = ((SUM_W'(column) + SUM_W'(len)) > SUM_W'(line_width));
    head_emit  = wrap && (first_char != twwf_pkg::CH_LF);
    out_free   = !out_valid || out_ch.ready;
    emit_ok    = !hold_valid || out_free;
    emit_en    = (cmd.head && head_emit) || cmd.word;
    emit_char  = cmd.word ? rd_data : twwf_pkg::CH_LF;
    rd_addr    = LEN_W'(idx) + (cmd.word ? LEN_W'(1) : LEN_W'(0));
    last_index = ((LEN_W'(idx) + LEN_W'(1)) == len);
    bumped     = (column == '1) ? column : column + 1'b1;
    if (rd_data == twwf_pkg::CH_LF) begin
      col_word_next = '0;
    end else if (rd_data == twwf_pkg::CH_BS) begin
      col_word_next = (bumped >= 2) ? bumped - 2'd2 : '0;
    end else begin
      col_word_next = bumped;
    end
  end

  always_comb begin
    status.slot_any   = pre_valid || main_valid;
    status.take_flush = !bar_skip && ((x == twwf_pkg::CH_SP) || (x == twwf_pkg::CH_BS) ||
                        (x == twwf_pkg::CH_LF) || (len == LEN_W'(WORD_LIMIT)));
    status.head_ok    = !head_emit || emit_ok;
    status.emit_ok    = emit_ok;
    status.last_index = last_index;
    status.hold_valid = hold_valid;
    status.out_free   = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= twwf_pkg::LINE_WIDTH_RESET;
      cap        <= 1'b0;
      prev       <= twwf_pkg::CH_NUL;
      len        <= '0;
      column     <= '0;
      idx        <= '0;
      pre_valid  <= 1'b0;
      main_valid <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_width <= cfg_data;
      end
      if (cmd.load) begin
        if (in_cmd) begin
          prev       <= twwf_pkg::CH_LF;
          pre_valid  <= 1'b0;
          main_valid <= 1'b0;
        end else begin
          cap        <= cap_next;
          pre_valid  <= dec_pre_v;
          main_valid <= dec_main_v;
          if (col_reset) begin
            column <= '0;
          end
        end
      end
      if (cmd.take) begin
        prev <= x;
        if (pre_valid) begin
          pre_valid <= 1'b0;
        end else begin
          main_valid <= 1'b0;
        end
        if (!bar_skip) begin
          len <= len + 1'b1;
        end
      end
      if (cmd.head && wrap) begin
        column <= '0;
        prev   <= twwf_pkg::CH_LF;
      end
      if (cmd.word) begin
        prev   <= rd_data;
        column <= col_word_next;
        if (last_index) begin
          len <= '0;
          idx <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (emit_en) begin
        if (hold_valid) begin
          out_valid <= 1'b1;
        end
        hold_valid <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pre_char  <= dec_pre_c;
      main_char <= dec_c;
    end
    if (cmd.take && !bar_skip && (len == '0)) begin
      first_char <= x;
    end
    if (emit_en) begin
      if (hold_valid) begin
        out_char <= hold_char;
        out_last <= 1'b0;
      end
      hold_char <= emit_char;
    end
    if (cmd.finish) begin
      out_char <= hold_char;
      out_last <= 1'b1;
    end
  end

  // word store
  always_ff @(posedge clk) begin
    if (cmd.take && !bar_skip) begin
      mem[len[IDX_W-1:0]] <= x;
    end
    if (rd_addr < LEN_W'(DEPTH)) begin
      rd_data <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_char    = out_char;
  assign out_ch.last_of_run = out_last;

endmodule
`default_nettype wire

// ----- src/text_word_wrap_formatter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_word_wrap_formatter_unit
// Game text to console formatter with word buffering and line wrap.
// ----------------------------------------------------------------------------
// One item is taken at a time. An item runs through an accept step, one
// step per character it takes toward the word store (an inserted space or
// paragraph line feed adds one) and a closing step. Each word that an item
// completes adds a line check step and then a read of each stored
// character in turn; the word store is read one entry per cycle while the
// output side has room.
// The output register and one held character decouple the output side;
// a stalled output holds the sequencer. The word store needs no clearing.
module text_word_wrap_formatter_unit #(
  parameter int WORD_LIMIT = 60
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  twwf_in_if.sink                          in_ch,
  twwf_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [twwf_pkg::CHAR_W-1:0] cfg_data
);

  twwf_pkg::cmd_t    cmd;
  twwf_pkg::status_t status;
  logic              in_ready;

  twwf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  twwf_dp #(
    .WORD_LIMIT (WORD_LIMIT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_cmd          (in_ch.cmd),
    .in_char_code    (in_ch.char_code),
    .in_side_channel (in_ch.side_channel),
    .in_plural       (in_ch.plural),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .out_ch          (out_ch)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

// ----- tb/tb_text_word_wrap_formatter_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_word_wrap_formatter_unit
// Self-checking bench for the game text word wrap formatter. A directed
// table walks capitalization, the substitutions, repeated space and line
// feed drops, the bar drop, backspace and the line read command, then
// random text at several line widths (zero and 127 among them) runs
// against a local model of the formatter. Long words, wraps, bursty input
// and a stalling console side are covered.
// ----------------------------------------------------------------------------
module tb_text_word_wrap_formatter_unit;
  import twwf_pkg::*;

  localparam int WORD_LIMIT   = 60;
  localparam int MAX_RUN      = 64;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int PHASE_ITEMS  = 70;
  localparam int SETTLE_CYC   = 64;

  typedef struct packed {
    logic             cmd;
    logic [CODE_W-1:0] code;
    logic             side;
    logic             plural;
  } text_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } console_item_t;

  typedef struct {
    logic                   cmd;
    logic [CODE_W-1:0]      code;
    logic                   side;
    logic                   plural;
    bit                     typed;
    int                     n;
    logic [0:3][CHAR_W-1:0] chars;
  } step_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CHAR_W-1:0] cfg_data;

  twwf_in_if  in_ch ();
  twwf_out_if out_ch ();

  text_word_wrap_formatter_unit #(.WORD_LIMIT(WORD_LIMIT)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // formatter model state
  logic [CHAR_W-1:0] width_m;
  bit                cap_m;
  logic [CHAR_W-1:0] prev_m;
  logic [CHAR_W-1:0] word_m [0:WORD_LIMIT];
  int unsigned       wlen_m;
  int unsigned       col_m;
  logic [CHAR_W-1:0] run_q [$];

  console_item_t console_q [$];
  console_item_t head_item;

  int unsigned cycles;
  int          bad_count;
  int          sent_count;
  int          checked_count;
  int          burst_left;
  bit          in_up;

  logic [CHAR_W-1:0] punct [0:3];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void flush_word();
    int unsigned i;
    logic [CHAR_W-1:0] ch;
    if (wlen_m + col_m > width_m) begin
      if (word_m[0] != CH_LF) run_q.push_back(CH_LF);
      col_m  = 0;
      prev_m = CH_LF;
    end
    for (i = 0; i < wlen_m; i++) begin
      ch = word_m[i];
      run_q.push_back(ch);
      prev_m = ch;
      if (col_m < 255) col_m++;
      if (ch == CH_LF) begin
        col_m  = 0;
        prev_m = CH_LF;
      end
      if (ch == CH_BS) col_m = (col_m >= 2) ? col_m - 2 : 0;
    end
    wlen_m = 0;
  endfunction

  function automatic void place_char(logic [CHAR_W-1:0] c);
    if (prev_m == CH_BAR) begin
      prev_m = c;
      return;
    end
    prev_m = c;
    if (wlen_m < WORD_LIMIT + 1) begin
      word_m[wlen_m] = c;
      wlen_m++;
    end
    if (c == CH_SP || c == CH_BS || c == CH_LF || wlen_m > WORD_LIMIT) flush_word();
  endfunction

  function automatic void format_item(text_item_t it);
    logic [CHAR_W-1:0] c;
    run_q.delete();
    c = it.code[CHAR_W-1:0];
    if (it.cmd) begin
      prev_m = CH_LF;
    end else if (c == CH_CAP) begin
      cap_m = 1'b1;
    end else if (c == CH_NUL) begin
      col_m = 0;
    end else if (!it.side) begin
      if (c == CH_CARET) c = CH_LF;
      if (c == CH_AT) c = it.plural ? CH_NUL : CH_S;
      if (cap_m) begin
        if (c > CH_GRAVE && c < CH_BAR) begin
          c     = c - CASE_OFS;
          cap_m = 1'b0;
        end else if ((c > CH_AT && c < CH_BSL) || c == CH_SQUOT || c == CH_DQUOT) begin
          cap_m = 1'b0;
        end
      end
      if (c == CH_TILDE || c == CH_EXCL || c == CH_DOT || c == CH_QUEST || c == CH_LF)
        cap_m = 1'b1;
      if (c == CH_CR) c = CH_LF;
      if ((c == CH_LF || c == CH_SP) && c == prev_m) c = CH_NUL;
      if (c == CH_TILDE) begin
        if (prev_m != CH_LF) place_char(CH_LF);
        c = CH_LF;
      end
      if (c == CH_UNDER) c = CH_SP;
      if (c != CH_NUL) begin
        if ((prev_m == CH_COMMA || prev_m == CH_DOT || prev_m == CH_EXCL ||
             prev_m == CH_QUEST) &&
            ((c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A)))
          place_char(CH_SP);
        place_char(c);
      end
    end
  endfunction

  function automatic text_item_t rand_item();
    text_item_t it;
    int unsigned p;
    p         = $urandom_range(0, 99);
    it.cmd    = 1'b0;
    it.side   = ($urandom_range(0, 29) == 0);
    it.plural = 1'($urandom_range(0, 1));
    if (p < 55)      it.code = CODE_W'($urandom_range(8'h61, 8'h7A));
    else if (p < 65) it.code = CODE_W'(CH_SP);
    else if (p < 71) it.code = CODE_W'(punct[$urandom_range(0, 3)]);
    else if (p < 73) it.code = CODE_W'(CH_CARET);
    else if (p < 75) it.code = CODE_W'(CH_AT);
    else if (p < 77) it.code = CODE_W'(CH_UNDER);
    else if (p < 79) it.code = CODE_W'(CH_TILDE);
    else if (p < 81) it.code = CODE_W'(CH_BAR);
    else if (p < 82) it.code = CODE_W'(CH_CR);
    else if (p < 84) it.code = CODE_W'(CH_BS);
    else if (p < 86) it.code = CODE_W'(CH_LF);
    else if (p < 88) it.code = CODE_W'(CH_CAP);
    else if (p < 89) it.code = CODE_W'(CH_NUL);
    else if (p < 92) it.code = CODE_W'($urandom_range(8'h41, 8'h5A));
    else if (p < 94) it.code = CODE_W'($urandom_range(0, 1) ? CH_SQUOT : CH_DQUOT);
    else if (p < 98) it.code = CODE_W'($urandom_range(0, 255));
    else begin
      it.cmd  = 1'b1;
      it.code = CODE_W'($urandom_range(0, 255));
      it.side = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 9) == 0) it.code[CODE_W-1] = 1'b1;
    return it;
  endfunction

  task automatic drop_valid();
    if (in_up) begin
      in_ch.valid <= 1'b0;
      in_up = 1'b0;
    end
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      drop_valid();
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_item(text_item_t it, bit typed, int tn,
                           logic [0:3][CHAR_W-1:0] tch);
    int n;
    int k;
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= it.cmd;
    in_ch.char_code    <= it.code;
    in_ch.side_channel <= it.side;
    in_ch.plural       <= it.plural;
    in_up = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    format_item(it);
    if (typed) begin
      for (k = 0; k < tn; k++)
        console_q.push_back('{ch: tch[k], last: (k == tn - 1)});
    end else begin
      n = (run_q.size() > MAX_RUN) ? MAX_RUN : run_q.size();
      for (k = 0; k < n; k++)
        console_q.push_back('{ch: run_q[k], last: (k == n - 1)});
    end
    pace();
  endtask

  task automatic wait_drained();
    drop_valid();
    while (console_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_width(logic [CHAR_W-1:0] w);
    cfg_we   <= 1'b1;
    cfg_data <= w;
    width_m = w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // console side: the stall pattern is redrawn whenever its random hold count runs out
  int unsigned rx_mode;
  int unsigned rx_left;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default: out_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      checked_count++;
      if (console_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected item: char %h last %b", out_ch.out_char, out_ch.last_of_run);
      end else begin
        head_item = console_q.pop_front();
        if (head_item.ch !== out_ch.out_char || head_item.last !== out_ch.last_of_run) begin
          bad_count++;
          if (bad_count <= 10)
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     head_item.ch, head_item.last, out_ch.out_char, out_ch.last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d items outstanding", console_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    step_row_t   rows [$];
    text_item_t  it;
    int          r;
    int          ph;
    int          cnt;
    int          len;
    int unsigned pick;
    logic [CHAR_W-1:0] widths [0:5];

    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = LINE_WIDTH_RESET;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = 1'b0;
    in_ch.char_code    = '0;
    in_ch.side_channel = 1'b0;
    in_ch.plural       = 1'b0;
    out_ch.ready       = 1'b0;
    rx_mode            = 0;
    rx_left            = 0;
    cycles             = 0;
    bad_count          = 0;
    sent_count         = 0;
    checked_count      = 0;
    burst_left         = 0;
    in_up              = 1'b0;
    width_m            = LINE_WIDTH_RESET;
    cap_m              = 1'b0;
    prev_m             = CH_NUL;
    wlen_m             = 0;
    col_m              = 0;
    punct              = '{CH_COMMA, CH_DOT, CH_EXCL, CH_QUEST};
    widths             = '{7'd20, 7'd127, 7'd0, 7'd120, 7'd78, 7'd1};

    // code, flags, then the console items where they are obvious
    rows.push_back('{1'b0, {1'b0, CH_CAP},   1'b0, 1'b0, 1'b1, 0, '0});
    rows.push_back('{1'b0, 8'h68,            1'b0, 1'b0, 1'b1, 0, '0});
    rows.push_back('{1'b0, 8'h69,            1'b0, 1'b0, 1'b1, 0, '0});
    rows.push_back('{1'b0, {1'b0, CH_DOT},   1'b0, 1'b0, 1'b1, 0, '0});
    rows.push_back('{1'b0, 8'h6F,            1'b0, 1'b0, 1'b1, 4,
                     {7'h48, 7'h69, CH_DOT, CH_SP}});
    rows.push_back('{1'b0, {1'b0, CH_AT},    1'b0, 1'b0, 1'b1, 0, '0});
    rows.push_back('{1'b0, {1'b0, CH_SP},    1'b0, 1'b0, 1'b1, 3,
                     {7'h4F, CH_S, CH_SP, 7'h00}});
    rows.push_back('{1'b0, {1'b0, CH_SP},    1'b0, 1'b0, 1'b1, 0, '0});
    rows.push_back('{1'b0, {1'b0, CH_AT},    1'b0, 1'b1, 1'b1, 0, '0});
    rows.push_back('{1'b0, {1'b0, CH_UNDER}, 1'b0, 1'b0, 1'b1, 1, {CH_SP, 21'h0}});
    rows.push_back('{1'b0, {1'b0, CH_CARET}, 1'b0, 1'b0, 1'b1, 1, {CH_LF, 21'h0}});
    rows.push_back('{1'b0, {1'b0, CH_CR},    1'b0, 1'b0, 1'b0, 0, '0});
    rows.push_back('{1'b1, 8'h78,            1'b1, 1'b1, 1'b1, 0, '0});
    rows.push_back('{1'b0, {1'b0, CH_BAR},   1'b0, 1'b0, 1'b0, 0, '0});
    rows.push_back('{1'b0, 8'h71,            1'b0, 1'b0, 1'b0, 0, '0});
    rows.push_back('{1'b0, 8'h7A,            1'b1, 1'b0, 1'b0, 0, '0});
    rows.push_back('{1'b0, 8'h80,            1'b0, 1'b0, 1'b1, 0, '0});
    rows.push_back('{1'b0, 8'hFF,            1'b1, 1'b0, 1'b1, 0, '0});
    rows.push_back('{1'b0, 8'h7B,            1'b0, 1'b0, 1'b0, 0, '0});
    rows.push_back('{1'b0, {1'b0, CH_BS},    1'b0, 1'b0, 1'b1, 3,
                     {CH_BAR, 7'h5B, CH_BS, 7'h00}});
    rows.push_back('{1'b0, {1'b0, CH_TILDE}, 1'b0, 1'b0, 1'b1, 2, {CH_LF, CH_LF, 14'h0}});
    rows.push_back('{1'b0, {1'b0, CH_TILDE}, 1'b0, 1'b0, 1'b0, 0, '0});
    rows.push_back('{1'b0, {1'b0, CH_LF},    1'b0, 1'b0, 1'b0, 0, '0});
    rows.push_back('{1'b0, {1'b0, CH_DQUOT}, 1'b0, 1'b0, 1'b0, 0, '0});
    rows.push_back('{1'b0, {1'b0, CH_EXCL},  1'b0, 1'b0, 1'b0, 0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < rows.size(); r++) begin
      it.cmd    = rows[r].cmd;
      it.code   = rows[r].code;
      it.side   = rows[r].side;
      it.plural = rows[r].plural;
      send_item(it, rows[r].typed, rows[r].n, rows[r].chars);
    end

    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      set_width((ph == 4) ? 7'($urandom_range(20, 120)) : widths[ph]);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          // word of 55 to 70 letters, which may run past the store limit
          len = $urandom_range(55, 70);
          repeat (len) begin
            it        = '0;
            it.code   = CODE_W'($urandom_range(8'h61, 8'h7A));
            it.plural = 1'($urandom_range(0, 1));
            send_item(it, 1'b0, 0, '0);
          end
          cnt += len;
        end else if (pick < 4) begin
          wait_drained();
        end else begin
          send_item(rand_item(), 1'b0, 0, '0);
          cnt++;
        end
      end
    end

    wait_drained();

    $display("%0d text items in, %0d console items compared, six line widths",
             sent_count, checked_count);
    $display("widths ran from 0 to 127 with long words, wraps and stalls");
    if (bad_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", bad_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/twwf_pkg.sv
src/twwf_in_if.sv
src/twwf_out_if.sv
src/twwf_ctrl.sv
src/twwf_dp.sv
src/text_word_wrap_formatter_unit.sv
tb/tb_text_word_wrap_formatter_unit.sv
